@@ sv/ffa_pkg.sv @@
// ffa_pkg: shared types and constants for the first-fit free list allocator
// no dependencies; used by ffa_ctrl, ffa_datapath and the top level
`timescale 1ns / 1ps

package ffa_pkg;

   // free list depth and derived widths
   localparam int FREE_DEPTH = 16;
   localparam int CNT_W      = $clog2(FREE_DEPTH + 1);

   // payload widths
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 24;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 1;

   // block header in front of every carved area
   localparam logic [ADDR_W-1:0] HEADER_BYTES = 32'd8;

   // request kinds
   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_REUSED      = 3'd0,
      ST_NEW_AREA    = 3'd1,
      ST_OUT_OF_HEAP = 3'd2,
      ST_FREED       = 3'd3,
      ST_LIST_FULL   = 3'd4
   } status_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 1'b1;

   // controller states
   typedef enum logic {
      S_IDLE   = 1'b0,
      S_COMMIT = 1'b1
   } fsm_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic commit;
   } ctl_cmd_type;

endpackage

@@ sv/ffa_ctrl.sv @@
// ffa_ctrl: two-state sequencer for the allocator
// depends on ffa_pkg; drives command strobes into ffa_datapath
`timescale 1ns / 1ps

module ffa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output ffa_pkg::ctl_cmd_type cmd
);

   ffa_pkg::fsm_state_type state_ff;
   ffa_pkg::fsm_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffa_pkg::S_IDLE: begin
            if (start) begin
               state_in = ffa_pkg::S_COMMIT;
            end
         end
         ffa_pkg::S_COMMIT: begin
            state_in = ffa_pkg::S_IDLE;
         end
         default: begin
            state_in = ffa_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy       = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ffa_pkg::S_IDLE: begin
            cmd.load = start;
         end
         ffa_pkg::S_COMMIT: begin
            busy       = 1'b1;
            cmd.commit = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/ffa_datapath.sv @@
// ffa_datapath: free list lanes, first-fit search, break pointer and result registers
// depends on ffa_pkg; sequenced by ffa_ctrl
`timescale 1ns / 1ps

module ffa_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ffa_pkg::ctl_cmd_type                   cmd,
   input  logic                                   req_type,
   input  logic [ffa_pkg::LEN_W-1:0]              req_size,
   input  logic [ffa_pkg::ADDR_W-1:0]             req_address,
   input  logic                                   csr_write_enable,
   input  logic [ffa_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ffa_pkg::ADDR_W-1:0]             csr_write_data,
   output logic                                   rsp_valid,
   output logic [ffa_pkg::ADDR_W-1:0]             rsp_user_address,
   output logic [ffa_pkg::LEN_W-1:0]              rsp_granted_length,
   output logic [ffa_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int D = ffa_pkg::FREE_DEPTH;

   // free list lanes, lane 0 newest; no reset, valid below count
   logic [ffa_pkg::ADDR_W-1:0] lane_addr_ff [D];
   logic [ffa_pkg::ADDR_W-1:0] lane_addr_in [D];
   logic [ffa_pkg::LEN_W-1:0]  lane_len_ff  [D];
   logic [ffa_pkg::LEN_W-1:0]  lane_len_in  [D];
   logic [ffa_pkg::CNT_W-1:0]  count_ff;
   logic [ffa_pkg::CNT_W-1:0]  count_in;

   // break pointer and limit
   logic [ffa_pkg::ADDR_W-1:0] bp_ff;
   logic [ffa_pkg::ADDR_W-1:0] bp_in;
   logic [ffa_pkg::ADDR_W-1:0] limit_ff;
   logic [ffa_pkg::ADDR_W-1:0] limit_in;

   // latched item and search results
   ffa_pkg::req_kind_type      kind_ff;
   logic [ffa_pkg::LEN_W-1:0]  size_ff;
   logic [ffa_pkg::ADDR_W-1:0] addr_ff;
   logic [D-1:0]               ge_ff;
   logic [D-1:0]               ge_in;
   logic [ffa_pkg::ADDR_W:0]   next_sum_ff;
   logic [ffa_pkg::ADDR_W-1:0] bump_addr_ff;

   // result registers
   logic                         rsp_valid_ff;
   logic [ffa_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [ffa_pkg::ADDR_W-1:0]   rsp_addr_in;
   logic [ffa_pkg::LEN_W-1:0]    rsp_len_ff;
   logic [ffa_pkg::LEN_W-1:0]    rsp_len_in;
   ffa_pkg::status_type          rsp_status_ff;
   ffa_pkg::status_type          rsp_status_in;

   // commit-side helpers
   logic [D-1:0]               first_hit;
   logic                       hit;
   logic                       full;
   logic                       out_of_heap;
   logic [ffa_pkg::ADDR_W-1:0] sel_addr;
   logic [ffa_pkg::LEN_W-1:0]  sel_len;

   // first-fit search on the incoming item: running OR of fitting valid lanes
   always_comb begin
      logic fit;
      ge_in = '0;
      for (int i = 0; i < D; i++) begin
         fit = (ffa_pkg::CNT_W'(i) < count_ff) && (lane_len_ff[i] >= req_size);
         if (i == 0) begin
            ge_in[i] = fit;
         end else begin
            ge_in[i] = ge_in[i-1] | fit;
         end
      end
   end

   // latch item, search mask and bump sums at accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff      <= ffa_pkg::req_kind_type'(req_type);
         size_ff      <= req_size;
         addr_ff      <= req_address;
         ge_ff        <= ge_in;
         next_sum_ff  <= {1'b0, bp_ff} + {9'd0, req_size} + {1'b0, ffa_pkg::HEADER_BYTES};
         bump_addr_ff <= bp_ff + ffa_pkg::HEADER_BYTES;
      end
   end

   // pick the first fitting lane
   assign first_hit   = ge_ff & ~(ge_ff << 1);
   assign hit         = ge_ff[D-1];
   assign full        = (count_ff == ffa_pkg::CNT_W'(D));
   assign out_of_heap = (next_sum_ff > {1'b0, limit_ff});

   always_comb begin
      sel_addr = '0;
      sel_len  = '0;
      for (int i = 0; i < D; i++) begin
         if (first_hit[i]) begin
            sel_addr = sel_addr | lane_addr_ff[i];
            sel_len  = sel_len | lane_len_ff[i];
         end
      end
   end

   // lane, count, break and result updates
   always_comb begin
      for (int i = 0; i < D; i++) begin
         lane_addr_in[i] = lane_addr_ff[i];
         lane_len_in[i]  = lane_len_ff[i];
      end
      count_in      = count_ff;
      bp_in         = bp_ff;
      limit_in      = limit_ff;
      rsp_addr_in   = '0;
      rsp_len_in    = '0;
      rsp_status_in = ffa_pkg::ST_FREED;

      if (cmd.commit) begin
         if (kind_ff == ffa_pkg::REQ_FREE) begin
            if (full) begin
               rsp_status_in = ffa_pkg::ST_LIST_FULL;
            end else begin
               // push on the front
               lane_addr_in[0] = addr_ff;
               lane_len_in[0]  = size_ff;
               for (int i = 1; i < D; i++) begin
                  lane_addr_in[i] = lane_addr_ff[i-1];
                  lane_len_in[i]  = lane_len_ff[i-1];
               end
               count_in      = count_ff + 1'b1;
               rsp_status_in = ffa_pkg::ST_FREED;
            end
         end else if (hit) begin
            // unlink the hit, later lanes move down one
            for (int i = 0; i < D - 1; i++) begin
               if (ge_ff[i]) begin
                  lane_addr_in[i] = lane_addr_ff[i+1];
                  lane_len_in[i]  = lane_len_ff[i+1];
               end
            end
            count_in      = count_ff - 1'b1;
            rsp_addr_in   = sel_addr;
            rsp_len_in    = sel_len;
            rsp_status_in = ffa_pkg::ST_REUSED;
         end else if (out_of_heap) begin
            rsp_status_in = ffa_pkg::ST_OUT_OF_HEAP;
         end else begin
            bp_in         = next_sum_ff[ffa_pkg::ADDR_W-1:0];
            rsp_addr_in   = bump_addr_ff;
            rsp_len_in    = size_ff;
            rsp_status_in = ffa_pkg::ST_NEW_AREA;
         end
      end

      // configuration writes; the user must write only while idle, this block does not enforce it
      if (csr_write_enable) begin
         case (csr_index)
            ffa_pkg::CSR_HEAP_START: bp_in    = csr_write_data;
            ffa_pkg::CSR_HEAP_LIMIT: limit_in = csr_write_data;
            default: begin
               limit_in = limit_ff;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         bp_ff        <= '0;
         limit_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         bp_ff        <= bp_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= cmd.commit;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      for (int i = 0; i < D; i++) begin
         lane_addr_ff[i] <= lane_addr_in[i];
         lane_len_ff[i]  <= lane_len_in[i];
      end
      if (cmd.commit) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_user_address   = rsp_addr_ff;
   assign rsp_granted_length = rsp_len_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

@@ sv/first_fit_free_list_allocator_top.sv @@
// first_fit_free_list_allocator_top: allocator top level
// depends on ffa_pkg, ffa_ctrl and ffa_datapath
`timescale 1ns / 1ps

// Heap allocator with a 16-entry newest-first free list. An item is taken on a
// clock edge with start high and busy low. Busy is then high for one cycle. The
// result shows on the rsp_ ports, marked by rsp_valid, for exactly one cycle.
// That cycle starts at the edge after acceptance. A new item can be taken while
// the previous result shows. The first-fit search runs in the accept cycle. The
// unlink, push or break bump runs in the commit cycle. The receiver cannot stall:
// rsp_valid is not held, so capture the result in the cycle it shows. Write
// heap_start and heap_limit only while busy is low and no result is pending.
// Writing heap_start also reloads the break pointer.

module first_fit_free_list_allocator_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_type,
   input  logic [ffa_pkg::LEN_W-1:0]              req_size,
   input  logic [ffa_pkg::ADDR_W-1:0]             req_address,
   output logic                                   rsp_valid,
   output logic [ffa_pkg::ADDR_W-1:0]             rsp_user_address,
   output logic [ffa_pkg::LEN_W-1:0]              rsp_granted_length,
   output logic [ffa_pkg::STATUS_W-1:0]           rsp_status,
   input  logic                                   csr_write_enable,
   input  logic [ffa_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ffa_pkg::ADDR_W-1:0]             csr_write_data
);

   ffa_pkg::ctl_cmd_type cmd;

   // sequencer
   ffa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // free list and break datapath
   ffa_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_type           (req_type),
      .req_size           (req_size),
      .req_address        (req_address),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_user_address   (rsp_user_address),
      .rsp_granted_length (rsp_granted_length),
      .rsp_status         (rsp_status)
   );

endmodule
